// ===== sv/ovle_pkg.sv =====
// Ordered value list engine: shared types and constants.
// Used by ovle_store and ordered_value_list_engine; no dependencies.
package ovle_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = 32;

  localparam logic [1:0] CMD_APPEND   = 2'd0;
  localparam logic [1:0] CMD_TRAVERSE = 2'd1;
  localparam logic [1:0] CMD_DELETE   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]           command;
    logic signed [DW-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] item_value;
    status_e              status;
    logic                 last;
  } out_t;

  typedef struct packed {
    logic                 en;
    logic [IW-1:0]        addr;
    logic signed [DW-1:0] data;
  } ram_wr_t;

endpackage

// ===== sv/ovle_store.sv =====
// Value store: CAPACITY x 32 synchronous RAM, one write and one read port.
// Read data is registered. Depends on ovle_pkg.
module ovle_store (
  input  logic                          clk_i,
  input  ovle_pkg::ram_wr_t             wr_i,
  input  logic [ovle_pkg::IW-1:0]       raddr_i,
  output logic signed [ovle_pkg::DW-1:0] rdata_o
);

  logic signed [ovle_pkg::DW-1:0] mem_q [ovle_pkg::CAPACITY];
  logic signed [ovle_pkg::DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ordered_value_list_engine.sv =====
// Ordered value list engine, top level: command sequencer around ovle_store.
// Append and empty-list commands: one result the cycle after the transfer, busy_o stays low.
// Traverse and delete sweep the RAM one entry per cycle with busy_o high
// (N = stored count); traverse gives N results through the RAM read and result registers.
// Delete result follows the sweep. Results are strobes; the receiver cannot stall.
// Async active-low reset empties the list; RAM contents are not cleared.
module ordered_value_list_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ovle_pkg::in_t in_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output ovle_pkg::out_t res_o
);

  typedef enum logic {
    S_IDLE,
    S_SWEEP
  } state_e;

  localparam logic [ovle_pkg::CW-1:0] CapW = ovle_pkg::CW'(ovle_pkg::CAPACITY);

  state_e                          state_q;
  logic [ovle_pkg::CW-1:0]         count_q;
  logic [ovle_pkg::CW-1:0]         rd_idx_q;
  logic [ovle_pkg::IW-1:0]         dat_idx_q;
  logic                            dv_q;
  logic                            found_q;
  logic [1:0]                      op_q;
  logic signed [ovle_pkg::DW-1:0]  val_q;
  logic                            res_valid_q;
  ovle_pkg::out_t                  res_q;

  ovle_pkg::ram_wr_t               wr;
  logic signed [ovle_pkg::DW-1:0]  rdata;
  logic                            issue;
  logic                            is_last;

  assign issue   = (state_q == S_SWEEP) && (rd_idx_q < count_q);
  assign is_last = ({1'b0, dat_idx_q} == ovle_pkg::CW'(count_q - 1'b1));

  always_comb begin
    wr = '0;
    if (state_q == S_IDLE && start_i && in_i.command == ovle_pkg::CMD_APPEND &&
        count_q < CapW) begin
      wr = '{en: 1'b1, addr: count_q[ovle_pkg::IW-1:0], data: in_i.value};
    end else if (state_q == S_SWEEP && dv_q && op_q == ovle_pkg::CMD_DELETE &&
                 found_q) begin
      // shift entry down over the removed slot
      wr = '{en: 1'b1, addr: dat_idx_q - 1'b1, data: rdata};
    end
  end

  ovle_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (rd_idx_q[ovle_pkg::IW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      dat_idx_q   <= '0;
      dv_q        <= 1'b0;
      found_q     <= 1'b0;
      op_q        <= ovle_pkg::CMD_APPEND;
      val_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            case (in_i.command)
              ovle_pkg::CMD_APPEND: begin
                res_valid_q <= 1'b1;
                if (count_q < CapW) begin
                  count_q <= count_q + 1'b1;
                  res_q   <= '{item_value: '0, status: ovle_pkg::ST_OK, last: 1'b1};
                end else begin
                  res_q   <= '{item_value: '0, status: ovle_pkg::ST_FULL, last: 1'b1};
                end
              end
              ovle_pkg::CMD_TRAVERSE, ovle_pkg::CMD_DELETE: begin
                if (count_q == '0) begin
                  res_valid_q <= 1'b1;
                  res_q <= '{item_value: '0, status: ovle_pkg::ST_EMPTY, last: 1'b1};
                end else begin
                  state_q  <= S_SWEEP;
                  op_q     <= in_i.command;
                  val_q    <= in_i.value;
                  rd_idx_q <= '0;
                  dv_q     <= 1'b0;
                  found_q  <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_SWEEP: begin
          dv_q      <= issue;
          dat_idx_q <= rd_idx_q[ovle_pkg::IW-1:0];
          if (issue) begin
            rd_idx_q <= rd_idx_q + 1'b1;
          end
          if (dv_q) begin
            if (op_q == ovle_pkg::CMD_TRAVERSE) begin
              res_valid_q <= 1'b1;
              res_q <= '{item_value: rdata, status: ovle_pkg::ST_OK, last: is_last};
            end else if (!found_q && rdata == val_q) begin
              found_q <= 1'b1;
            end
          end
          if (!issue && !dv_q) begin
            state_q <= S_IDLE;
            if (op_q == ovle_pkg::CMD_DELETE) begin
              res_valid_q <= 1'b1;
              if (found_q) begin
                count_q <= count_q - 1'b1;
                res_q <= '{item_value: '0, status: ovle_pkg::ST_OK, last: 1'b1};
              end else begin
                res_q <= '{item_value: '0, status: ovle_pkg::ST_NOTFOUND, last: 1'b1};
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapW)
    else $error("entry count above capacity");

  a_sweep_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP && wr.en) |-> (found_q && op_q == ovle_pkg::CMD_DELETE))
    else $error("RAM write during sweep without a match");

  a_dv_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q |-> state_q == S_SWEEP)
    else $error("read data valid outside sweep");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != ovle_pkg::ST_OK) |-> res_o.item_value == '0)
    else $error("status result carries nonzero value");
`endif

endmodule

// ===== verif/ovle_checker.sv =====
`timescale 1ns / 100ps
// Ordered value list engine checker: predicts the results of every command transfer
// and compares each result strobe with the oldest prediction. Depends on ovle_pkg.
module ovle_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  ovle_pkg::in_t  in_i,
  input  logic           res_valid_i,
  input  ovle_pkg::out_t res_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o,
  output int unsigned    checked_o
);

  logic signed [ovle_pkg::DW-1:0] list_vals [ovle_pkg::CAPACITY];
  int unsigned                    list_len = 0;
  ovle_pkg::out_t                 due_results [$];
  int unsigned                    mismatches = 0;
  int unsigned                    checked = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = due_results.size();
  assign checked_o    = checked;

  function automatic ovle_pkg::out_t status_result(input ovle_pkg::status_e st);
    ovle_pkg::out_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  task automatic run_list_command(input ovle_pkg::in_t cmd);
    int unsigned    i;
    ovle_pkg::out_t r;
    case (cmd.command)
      ovle_pkg::CMD_APPEND: begin
        if (list_len >= ovle_pkg::CAPACITY) begin
          due_results.push_back(status_result(ovle_pkg::ST_FULL));
        end else begin
          list_vals[list_len] = cmd.value;
          list_len++;
          due_results.push_back(status_result(ovle_pkg::ST_OK));
        end
      end
      ovle_pkg::CMD_TRAVERSE: begin
        if (list_len == 0) begin
          due_results.push_back(status_result(ovle_pkg::ST_EMPTY));
        end else begin
          for (i = 0; i < list_len; i++) begin
            r.item_value = list_vals[i];
            r.status     = ovle_pkg::ST_OK;
            r.last       = (i + 1 == list_len);
            due_results.push_back(r);
          end
        end
      end
      ovle_pkg::CMD_DELETE: begin
        if (list_len == 0) begin
          due_results.push_back(status_result(ovle_pkg::ST_EMPTY));
        end else begin
          i = 0;
          while (i < list_len && list_vals[i] != cmd.value) i++;
          if (i == list_len) begin
            due_results.push_back(status_result(ovle_pkg::ST_NOTFOUND));
          end else begin
            for (; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
            list_len--;
            due_results.push_back(status_result(ovle_pkg::ST_OK));
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input ovle_pkg::out_t got);
    ovle_pkg::out_t want;
    checked++;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with nothing pending: value=%0d status=%0d last=%b",
                 $realtime, got.item_value, got.status, got.last);
    end else begin
      want = due_results.pop_front();
      if (got.item_value !== want.item_value || got.status !== want.status ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch: expected value=%0d status=%0d last=%b, ",
                    "got value=%0d status=%0d last=%b"},
                   $realtime, want.item_value, want.status, want.last,
                   got.item_value, got.status, got.last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      due_results.delete();
    end else begin
      if (res_valid_i) check_result(res_i);
      if (start_i && !busy_i) run_list_command(in_i);
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Ordered value list engine testbench top: clock, reset, directed and random command
// stimulus with sender gaps, and the verdict. Depends on ovle_pkg and ovle_checker.
module testbench;

  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam int unsigned RANDOM_ITEMS  = 392;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 40;

  localparam int unsigned MODE_FILL  = 0;
  localparam int unsigned MODE_DRAIN = 1;
  localparam int unsigned MODE_MIXED = 2;

  logic           clk_i   = 1'b0;
  logic           rst_ni  = 1'b0;
  logic           start_i = 1'b0;
  ovle_pkg::in_t  in_i    = '0;
  logic           busy_o;
  logic           res_valid_o;
  ovle_pkg::out_t res_o;
  int unsigned    fail_count;
  int unsigned    pending;
  int unsigned    checked;
  int unsigned    cycle_cnt = 0;
  int unsigned    idle_pct  = 0;
  int unsigned    cmd_cnt [4] = '{0, 0, 0, 0};
  logic signed [ovle_pkg::DW-1:0] value_pool [6];

  always #10 clk_i = ~clk_i;

  ordered_value_list_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .in_i       (in_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  ovle_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .in_i        (in_i),
    .res_valid_i (res_valid_o),
    .res_i       (res_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Drive one command and hold it until the transfer.
  task automatic send(input logic [1:0] cmd, input logic signed [ovle_pkg::DW-1:0] val);
    @(negedge clk_i);
    start_i      = 1'b1;
    in_i.command = cmd;
    in_i.value   = val;
    do @(posedge clk_i); while (busy_o);
    cmd_cnt[cmd]++;
  endtask

  task automatic maybe_idle;
    int unsigned gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 3);
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  function automatic logic signed [ovle_pkg::DW-1:0] pick_value(input int unsigned pool_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < pool_pct) return value_pool[$urandom_range(5)];
    if (r < pool_pct + 6) return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    return $urandom;
  endfunction

  initial begin
    int unsigned                    items;
    int unsigned                    episode_left;
    int unsigned                    mode;
    int unsigned                    r;
    int unsigned                    app_lim;
    int unsigned                    trav_lim;
    int unsigned                    phase_pct [4];
    logic [1:0]                     cmd;
    logic signed [ovle_pkg::DW-1:0] val;

    phase_pct = '{0, 60, 0, 16};
    items = 0;
    episode_left = 0;
    mode = MODE_MIXED;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty list, extremes, head/middle/tail delete, duplicates, unused code
    send(ovle_pkg::CMD_TRAVERSE, 32'sd0);
    send(ovle_pkg::CMD_DELETE, 32'sd0);
    send(CMD_UNUSED, 32'sh7fffffff);
    send(ovle_pkg::CMD_APPEND, 32'sh80000000);
    send(ovle_pkg::CMD_APPEND, 32'sh7fffffff);
    send(ovle_pkg::CMD_APPEND, 32'sd0);
    send(ovle_pkg::CMD_APPEND, -32'sd1);
    send(ovle_pkg::CMD_TRAVERSE, -32'sd1);
    send(ovle_pkg::CMD_DELETE, 32'sd12345);
    send(ovle_pkg::CMD_DELETE, 32'sh7fffffff);
    send(ovle_pkg::CMD_DELETE, 32'sh80000000);
    send(ovle_pkg::CMD_DELETE, -32'sd1);
    send(ovle_pkg::CMD_APPEND, 32'sd7);
    send(ovle_pkg::CMD_APPEND, 32'sd0);
    send(ovle_pkg::CMD_DELETE, 32'sd0);
    send(ovle_pkg::CMD_TRAVERSE, 32'sh80000000);
    send(CMD_UNUSED, 32'sd0);

    // random: fill, drain and mixed episodes over a small value pool so deletes hit
    while (items < RANDOM_ITEMS) begin
      if (episode_left == 0) begin
        mode = $urandom_range(2);
        episode_left = $urandom_range(20, 40);
        foreach (value_pool[i])
          value_pool[i] = (i < 3) ? $urandom : $signed($urandom_range(8)) - 4;
      end
      idle_pct = phase_pct[(items / 50) % 4];
      case (mode)
        MODE_FILL: begin
          app_lim  = 70;
          trav_lim = 80;
        end
        MODE_DRAIN: begin
          app_lim  = 15;
          trav_lim = 30;
        end
        default: begin
          app_lim  = 40;
          trav_lim = 60;
        end
      endcase
      r = $urandom_range(99);
      if (r < app_lim) begin
        cmd = ovle_pkg::CMD_APPEND;
        val = pick_value(75);
      end else if (r < trav_lim) begin
        cmd = ovle_pkg::CMD_TRAVERSE;
        val = $urandom;
      end else if (r < 96) begin
        cmd = ovle_pkg::CMD_DELETE;
        val = pick_value(85);
      end else begin
        cmd = CMD_UNUSED;
        val = $urandom;
      end
      maybe_idle();
      send(cmd, val);
      episode_left--;
      if (cmd != CMD_UNUSED) items++;
    end

    @(negedge clk_i);
    start_i = 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Sent %0d appends, %0d traversals, %0d deletes and %0d unused codes.",
             cmd_cnt[ovle_pkg::CMD_APPEND], cmd_cnt[ovle_pkg::CMD_TRAVERSE],
             cmd_cnt[ovle_pkg::CMD_DELETE], cmd_cnt[CMD_UNUSED]);
    $display("Checked %0d results in %0d cycles, %0d mismatches.",
             checked, cycle_cnt, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
